>>> sv/kikc_pkg.sv
// ----------------------------------------------------------------------------
// kikc_pkg
// Shared types and constants of the keyspace index / key converter.
// ----------------------------------------------------------------------------
package kikc_pkg;

    localparam int INDEX_W     = 64;
    localparam int CHAR_W      = 8;
    localparam int RADIX_W     = 8;
    localparam int LEN_W       = 5;
    localparam int POS_W       = 4;
    localparam int SLOT_W      = 7;
    localparam int REQ_W       = 2;
    localparam int POS_CAP     = 16;
    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = INDEX_W / DIV_BITS;
    localparam int DIV_STEP_W  = $clog2(DIV_STEPS);

    localparam logic [REQ_W-1:0] REQ_WRITE    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TO_KEY   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TO_INDEX = 2'd2;

    localparam logic CFG_CHARSET_SIZE = 1'b0;
    localparam logic CFG_KEY_LEN      = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIV_WAIT,
        ST_READ,
        ST_EMIT,
        ST_SRCH,
        ST_MAC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               done;
        logic [RADIX_W-1:0] rem;
        logic [INDEX_W-1:0] quot;
    } div_result_t;

endpackage

>>> sv/keyspace_index_key_converter.sv
// ----------------------------------------------------------------------------
// keyspace_index_key_converter
// Converts between a 64-bit keyspace index and a fixed-length key over a
// charset held in an on-chip store.
// ----------------------------------------------------------------------------
// The input channel carries one request per handshake. A charset write stores
// slot_char at slot. An index request produces key_len character results, last
// position first; each digit passes through the iterative divider, then one
// store read and one output load. A key-character request scans the charset
// store one slot per cycle through its single read port; the request that
// completes a key produces one index result. Results leave through an output
// register, so a request is accepted as soon as the previous one has loaded
// its last result, even while that result still waits. When the receiver
// stalls, the block holds in its emit or done state with the result register
// full. Reset clears the control state, the accumulated index and the
// character count and restores charset_size to 26 and key_len to 8; the
// charset store is not cleared and must be written before use. Configuration
// writes are always ready.
// ----------------------------------------------------------------------------
module keyspace_index_key_converter
    import kikc_pkg::*;
#(
    parameter int CHARSET_DEPTH = 128,
    parameter int MAX_KEY_LEN   = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [INDEX_W-1:0] key_index,
    input  logic [CHAR_W-1:0]  key_char,
    input  logic [SLOT_W-1:0]  slot,
    input  logic [CHAR_W-1:0]  slot_char,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  out_char,
    output logic [POS_W-1:0]   out_pos,
    output logic               run_last,
    output logic [INDEX_W-1:0] out_index,
    output logic               index_ready,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [RADIX_W-1:0] cfg_data
);

    localparam int ADDR_W  = $clog2(CHARSET_DEPTH);
    localparam int LEN_CAP = (MAX_KEY_LEN < POS_CAP) ? MAX_KEY_LEN : POS_CAP;

    state_t state_reg, state_next;

    logic [RADIX_W-1:0] charset_size_reg;
    logic [LEN_W-1:0]   key_len_reg;
    logic [RADIX_W-1:0] radix;
    logic [LEN_W-1:0]   len;

    logic [INDEX_W-1:0] value_reg, value_next;
    logic [RADIX_W-1:0] rem_reg, rem_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic [RADIX_W-1:0] issue_reg, issue_next;
    logic [RADIX_W-1:0] pend_addr_reg, pend_addr_next;
    logic               pend_reg, pend_next;
    logic [RADIX_W-1:0] digit_reg, digit_next;
    logic [INDEX_W-1:0] accum_reg, accum_next;
    logic [POS_W-1:0]   count_reg, count_next;

    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic [POS_W-1:0]   out_pos_reg, out_pos_next;
    logic               run_last_reg, run_last_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic               index_ready_reg, index_ready_next;

    logic               out_free;
    logic               accept;
    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CHAR_W-1:0]  ram_rdata;
    logic               div_start;
    div_result_t        div_res;

    always_comb
    begin
        radix = charset_size_reg;
        if (charset_size_reg == '0)
        begin
            radix = RADIX_W'(1);
        end
        else if (32'(charset_size_reg) > CHARSET_DEPTH)
        begin
            radix = RADIX_W'(CHARSET_DEPTH);
        end
        len = key_len_reg;
        if (key_len_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (32'(key_len_reg) > LEN_CAP)
        begin
            len = LEN_W'(LEN_CAP);
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign ram_we    = accept && (req_type == REQ_WRITE) && (32'(slot) < CHARSET_DEPTH);
    assign div_start = (state_reg == ST_DIV);

    always_comb
    begin
        state_next       = state_reg;
        value_next       = value_reg;
        rem_next         = rem_reg;
        pos_next         = pos_reg;
        char_next        = char_reg;
        issue_next       = issue_reg;
        pend_addr_next   = pend_addr_reg;
        pend_next        = pend_reg;
        digit_next       = digit_reg;
        accum_next       = accum_reg;
        count_next       = count_reg;
        out_valid_next   = out_ready ? 1'b0 : out_valid_reg;
        out_char_next    = out_char_reg;
        out_pos_next     = out_pos_reg;
        run_last_next    = run_last_reg;
        out_index_next   = out_index_reg;
        index_ready_next = index_ready_reg;
        ram_re           = 1'b0;
        ram_raddr        = issue_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_TO_KEY:
                        begin
                            value_next = key_index;
                            pos_next   = POS_W'(len - LEN_W'(1));
                            state_next = ST_DIV;
                        end
                        REQ_TO_INDEX:
                        begin
                            char_next  = key_char;
                            issue_next = '0;
                            pend_next  = 1'b0;
                            state_next = ST_SRCH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_res.done)
                begin
                    rem_next   = div_res.rem;
                    value_next = div_res.quot;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                ram_raddr  = rem_reg[ADDR_W-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_char_next    = ram_rdata;
                    out_pos_next     = pos_reg;
                    run_last_next    = (pos_reg == '0);
                    out_index_next   = '0;
                    index_ready_next = 1'b0;
                    if (pos_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg - POS_W'(1);
                        state_next = ST_DIV;
                    end
                end
            end
            ST_SRCH:
            begin
                pend_next = 1'b0;
                if (issue_reg < radix)
                begin
                    ram_re         = 1'b1;
                    issue_next     = issue_reg + RADIX_W'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = issue_reg;
                end
                if (pend_reg && ram_rdata == char_reg)
                begin
                    digit_next = pend_addr_reg;
                    pend_next  = 1'b0;
                    state_next = ST_MAC;
                end
                else if (!pend_reg && issue_reg >= radix)
                begin
                    digit_next = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                accum_next = INDEX_W'(accum_reg * INDEX_W'(radix) + INDEX_W'(digit_reg));
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if ((LEN_W'(count_reg) + LEN_W'(1)) >= len)
                begin
                    if (out_free)
                    begin
                        out_valid_next   = 1'b1;
                        out_char_next    = '0;
                        out_pos_next     = '0;
                        run_last_next    = 1'b0;
                        out_index_next   = accum_reg;
                        index_ready_next = 1'b1;
                        accum_next       = '0;
                        count_next       = '0;
                        state_next       = ST_IDLE;
                    end
                end
                else
                begin
                    count_next = count_reg + POS_W'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            charset_size_reg <= RADIX_W'(26);
            key_len_reg      <= LEN_W'(8);
            accum_reg        <= '0;
            count_reg        <= '0;
            pend_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            accum_reg     <= accum_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CHARSET_SIZE: charset_size_reg <= cfg_data;
                    CFG_KEY_LEN:      key_len_reg      <= cfg_data[LEN_W-1:0];
                    default:          key_len_reg      <= key_len_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg       <= value_next;
        rem_reg         <= rem_next;
        pos_reg         <= pos_next;
        char_reg        <= char_next;
        issue_reg       <= issue_next;
        pend_addr_reg   <= pend_addr_next;
        digit_reg       <= digit_next;
        out_char_reg    <= out_char_next;
        out_pos_reg     <= out_pos_next;
        run_last_reg    <= run_last_next;
        out_index_reg   <= out_index_next;
        index_ready_reg <= index_ready_next;
    end

    kikc_charset_ram #(
        .DEPTH  (CHARSET_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(slot)),
        .wdata (slot_char),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kikc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (value_reg),
        .divisor  (radix),
        .result   (div_res)
    );

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign out_pos     = out_pos_reg;
    assign run_last    = run_last_reg;
    assign out_index   = out_index_reg;
    assign index_ready = index_ready_reg;

endmodule

>>> sv/kikc_charset_ram.sv
// ----------------------------------------------------------------------------
// kikc_charset_ram
// Charset store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kikc_charset_ram
    import kikc_pkg::*;
#(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CHAR_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/kikc_divider.sv
// ----------------------------------------------------------------------------
// kikc_divider
// Iterative 64-bit by 8-bit divider, eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module kikc_divider
    import kikc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [INDEX_W-1:0] dividend,
    input  logic [RADIX_W-1:0] divisor,
    output div_result_t        result
);

    logic [INDEX_W-1:0]    work_reg, work_next;
    logic [RADIX_W-1:0]    rem_reg, rem_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    always_comb
    begin
        logic [RADIX_W:0]    r;
        logic [DIV_BITS-1:0] q;
        logic [INDEX_W-1:0]  src;
        logic [RADIX_W-1:0]  r0;
        work_next = work_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        src = start ? dividend : work_reg;
        r0  = start ? '0 : rem_reg;
        r   = {1'b0, r0};
        q   = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r = {r[RADIX_W-1:0], src[INDEX_W-1-i]};
            if (r >= {1'b0, divisor})
            begin
                r = r - {1'b0, divisor};
                q[DIV_BITS-1-i] = 1'b1;
            end
        end
        if (start || busy_reg)
        begin
            work_next = {src[INDEX_W-DIV_BITS-1:0], q};
            rem_next  = r[RADIX_W-1:0];
            step_next = start ? DIV_STEP_W'(1) : DIV_STEP_W'(step_reg + 1'b1);
            if (!start && step_reg == DIV_STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign result.done = done_reg;
    assign result.rem  = rem_reg;
    assign result.quot = work_reg;

endmodule

>>> sv/kikc_checker.sv
// ----------------------------------------------------------------------------
// kikc_checker
// Port-level checks on the result channel of the converter.
// ----------------------------------------------------------------------------
module kikc_checker
    import kikc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [CHAR_W-1:0]  out_char,
    input logic [POS_W-1:0]   out_pos,
    input logic               run_last,
    input logic [INDEX_W-1:0] out_index,
    input logic               index_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_pos)
            && $stable(run_last) && $stable(out_index) && $stable(index_ready))
        else $error("result changed while stalled");

    a_index_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_ready |-> out_char == '0 && out_pos == '0 && !run_last)
        else $error("index result carries character fields");

    a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !index_ready |-> out_index == '0)
        else $error("character result carries an index");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_last |-> out_pos == '0)
        else $error("run end not at position zero");

endmodule

bind keyspace_index_key_converter kikc_checker u_kikc_checker (.*);

>>> bench/keyspace_index_key_converter_tb.sv
// ----------------------------------------------------------------------------
// keyspace_index_key_converter_tb
// Self-checking bench for the keyspace index / key converter. The charset
// store is filled first, then directed requests cover the extreme indexes, a
// full key run with unmatched and duplicated characters, and requests mixed
// into a run. Random requests follow under several register settings,
// including the clamped radix and key length cases and a key length lowered
// in the middle of a run. A scoreboard predicts every result and compares
// each one as it leaves the block, while both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keyspace_index_key_converter_tb;
    import kikc_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int STORE_DEPTH   = 128;
    localparam int KEY_LEN_CAP   = 16;
    localparam int SETTLE_CYCLES = 200;
    localparam int END_CYCLES    = 300;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int PHASE_ITEMS   = 18;

    typedef struct {
        logic [CHAR_W-1:0]  ch;
        logic [POS_W-1:0]   pos;
        logic               last;
        logic [INDEX_W-1:0] index;
        logic               done;
    } key_result_t;

    class conversion_tracker;
        logic [CHAR_W-1:0]  charset [STORE_DEPTH];
        logic [INDEX_W-1:0] accum;
        int                 char_count;
        logic [7:0]         size_reg;
        logic [4:0]         len_reg;
        key_result_t        expected_q [$];
        int                 errors;

        function new();
            accum      = '0;
            char_count = 0;
            size_reg   = 8'd26;
            len_reg    = 5'd8;
            errors     = 0;
            foreach (charset[i]) charset[i] = '0;
        endfunction

        function int radix();
            if (size_reg == 0) return 1;
            if (size_reg > STORE_DEPTH) return STORE_DEPTH;
            return size_reg;
        endfunction

        function int digits_per_key();
            if (len_reg == 0) return 1;
            if (len_reg > KEY_LEN_CAP) return KEY_LEN_CAP;
            return len_reg;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_register(logic idx, logic [RADIX_W-1:0] data);
            if (idx == CFG_CHARSET_SIZE) size_reg = data;
            else len_reg = data[4:0];
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [INDEX_W-1:0] idx,
                                   logic [CHAR_W-1:0] kc, logic [SLOT_W-1:0] sl,
                                   logic [CHAR_W-1:0] sc);
            int                 r;
            int                 n;
            int                 p;
            int                 j;
            int                 digit;
            bit                 found;
            logic [INDEX_W-1:0] v;
            logic [INDEX_W-1:0] rem;
            key_result_t        res;
            r = radix();
            n = digits_per_key();
            case (req)
                REQ_WRITE: charset[sl] = sc;
                REQ_TO_KEY: begin
                    v = idx;
                    for (p = n - 1; p >= 0; p--) begin
                        rem       = v % r;
                        v         = v / r;
                        res.ch    = charset[rem];
                        res.pos   = POS_W'(p);
                        res.last  = (p == 0);
                        res.index = '0;
                        res.done  = 1'b0;
                        expected_q.insert(expected_q.size(), res);
                    end
                end
                REQ_TO_INDEX: begin
                    digit = 0;
                    found = 1'b0;
                    for (j = 0; j < r && !found; j++) begin
                        if (charset[j] == kc) begin
                            digit = j;
                            found = 1'b1;
                        end
                    end
                    accum = accum * r + digit;
                    if (char_count + 1 >= n) begin
                        res.ch    = '0;
                        res.pos   = '0;
                        res.last  = 1'b0;
                        res.index = accum;
                        res.done  = 1'b1;
                        expected_q.insert(expected_q.size(), res);
                        accum      = '0;
                        char_count = 0;
                    end else begin
                        char_count = (char_count + 1) % 16;
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(key_result_t got);
            key_result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, char %0h pos %0d index %0h ready %0b",
                         $time, got.ch, got.pos, got.index, got.done);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("out_char", want.ch, got.ch);
            compare_field("out_pos", want.pos, got.pos);
            compare_field("run_last", want.last, got.last);
            compare_field("out_index", want.index, got.index);
            compare_field("index_ready", want.done, got.done);
        endfunction
    endclass

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [REQ_W-1:0]   req_type    = '0;
    logic [INDEX_W-1:0] key_index   = '0;
    logic [CHAR_W-1:0]  key_char    = '0;
    logic [SLOT_W-1:0]  slot        = '0;
    logic [CHAR_W-1:0]  slot_char   = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [CHAR_W-1:0]  out_char;
    logic [POS_W-1:0]   out_pos;
    logic               run_last;
    logic [INDEX_W-1:0] out_index;
    logic               index_ready;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic               cfg_index   = 1'b0;
    logic [RADIX_W-1:0] cfg_data    = '0;

    conversion_tracker tracker;
    bit                no_gaps = 1'b0;

    keyspace_index_key_converter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .key_index   (key_index),
        .key_char    (key_char),
        .slot        (slot),
        .slot_char   (slot_char),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .out_pos     (out_pos),
        .run_last    (run_last),
        .out_index   (out_index),
        .index_ready (index_ready),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [INDEX_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [CHAR_W-1:0] pick_key_char();
        if ($urandom_range(0, 99) < 85)
            return tracker.charset[$urandom_range(0, tracker.radix() - 1)];
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        int                 r;
        int                 i;
        logic [INDEX_W-1:0] span;
        r = $urandom_range(0, 99);
        if (r < 35) return rand64();
        if (r < 65) begin
            span = 64'd1;
            for (i = 0; i < tracker.digits_per_key() && span != 0; i++) begin
                if (span > ({INDEX_W{1'b1}} / tracker.radix())) span = '0;
                else span = span * tracker.radix();
            end
            if (span == 0) return rand64();
            return rand64() % span;
        end
        if (r < 75) return {INDEX_W{1'b1}};
        if (r < 85) return INDEX_W'($urandom_range(0, 300));
        return rand64() >> $urandom_range(1, 63);
    endfunction

    task automatic send_request(logic [REQ_W-1:0] req, logic [INDEX_W-1:0] idx,
                                logic [CHAR_W-1:0] kc, logic [SLOT_W-1:0] sl,
                                logic [CHAR_W-1:0] sc);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type  <= req;
        key_index <= idx;
        key_char  <= kc;
        slot      <= sl;
        slot_char <= sc;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_request(req, idx, kc, sl, sc);
    endtask

    task automatic send_key_char(logic [CHAR_W-1:0] kc);
        send_request(REQ_TO_INDEX, rand64(), kc, SLOT_W'($urandom), CHAR_W'($urandom));
    endtask

    task automatic send_to_key(logic [INDEX_W-1:0] idx);
        send_request(REQ_TO_KEY, idx, CHAR_W'($urandom), SLOT_W'($urandom), CHAR_W'($urandom));
    endtask

    task automatic send_write(logic [SLOT_W-1:0] sl, logic [CHAR_W-1:0] sc);
        send_request(REQ_WRITE, rand64(), CHAR_W'($urandom), sl, sc);
    endtask

    task automatic wait_idle(int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic program_registers(logic [RADIX_W-1:0] size, logic [RADIX_W-1:0] len);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CHARSET_SIZE;
        cfg_data  <= size;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.write_register(CFG_CHARSET_SIZE, size);
        cfg_index <= CFG_KEY_LEN;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.write_register(CFG_KEY_LEN, len);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_charset();
        int i;
        for (i = 0; i < STORE_DEPTH; i++) begin
            if (i < 26) send_write(SLOT_W'(i), CHAR_W'("a" + i));
            else if (i == 126) send_write(SLOT_W'(i), 8'h00);
            else if (i == 127) send_write(SLOT_W'(i), 8'hFF);
            else send_write(SLOT_W'(i), CHAR_W'(i * 73 + 11));
        end
    endtask

    task automatic run_directed();
        send_to_key('0);
        send_to_key({INDEX_W{1'b1}});
        send_to_key(64'd208827064575);
        send_to_key(64'd208827064576);
        send_request(REQ_UNUSED, rand64(), CHAR_W'($urandom), SLOT_W'($urandom),
                     CHAR_W'($urandom));
        // A key run with other requests mixed in, a duplicated charset entry
        // and characters that match no slot below the radix.
        send_key_char("z");
        send_key_char("a");
        send_write(SLOT_W'(20), "b");
        send_key_char("b");
        send_to_key(64'd12345);
        send_key_char(8'hFF);
        send_key_char(8'h00);
        send_key_char("k");
        send_request(REQ_UNUSED, rand64(), CHAR_W'($urandom), SLOT_W'($urandom),
                     CHAR_W'($urandom));
        send_key_char("q");
        send_key_char("y");
        send_key_char("u");
        send_write(SLOT_W'(20), "u");
    endtask

    task automatic run_random_phase(int budget, bit hold);
        int  sent;
        int  pick;
        int  n;
        int  i;
        bit  held;
        sent = 0;
        held = 1'b0;
        while (sent < budget) begin
            if (hold && !held && sent >= budget / 2) begin
                wait_idle(0);
                held = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                n = tracker.digits_per_key() - tracker.char_count;
                if (n < 1) n = 1;
                if (pick < 8) n = $urandom_range(1, n);
                for (i = 0; i < n; i++) send_key_char(pick_key_char());
                sent += n;
            end else if (pick < 80) begin
                send_to_key(pick_index());
                sent++;
            end else if (pick < 93) begin
                send_write(SLOT_W'($urandom), CHAR_W'($urandom));
                sent++;
            end else begin
                send_request(REQ_UNUSED, rand64(), CHAR_W'($urandom), SLOT_W'($urandom),
                             CHAR_W'($urandom));
            end
        end
    endtask

    task automatic run_phase(logic [RADIX_W-1:0] size, logic [RADIX_W-1:0] len, bit quiet,
                             bit hold, int partial);
        int i;
        int n;
        wait_idle(SETTLE_CYCLES);
        program_registers(size, len);
        no_gaps = quiet;
        send_to_key('0);
        send_to_key({INDEX_W{1'b1}});
        run_random_phase(PHASE_ITEMS, hold);
        if (partial > 0) begin
            // Finish the open run, then leave a long one open for the next setting.
            n = tracker.digits_per_key() - tracker.char_count;
            for (i = 0; i < n; i++) send_key_char(pick_key_char());
            for (i = 0; i < partial; i++) send_key_char(pick_key_char());
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        int stall_left;
        key_result_t got;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                got.ch    = out_char;
                got.pos   = out_pos;
                got.last  = run_last;
                got.index = out_index;
                got.done  = index_ready;
                tracker.check_result(got);
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        tracker = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_charset();
        run_directed();
        run_random_phase(PHASE_ITEMS, 1'b1);
        run_phase(8'd2,   8'd16,  1'b0, 1'b0, 0);
        run_phase(8'd1,   8'd1,   1'b1, 1'b0, 0);
        run_phase(8'd0,   8'd3,   1'b0, 1'b1, 0);
        run_phase(8'd128, 8'd16,  1'b0, 1'b0, 12);
        run_phase(8'd36,  8'd3,   1'b0, 1'b0, 0);
        run_phase(8'd255, 8'd31,  1'b1, 1'b0, 0);
        run_phase(8'd10,  8'd0,   1'b0, 1'b1, 0);
        run_phase(8'd16,  8'hE4,  1'b0, 1'b0, 0);
        run_phase(8'd200, 8'h55,  1'b0, 1'b0, 0);
        run_phase(8'd64,  8'd5,   1'b1, 1'b1, 0);
        run_phase(8'd129, 8'd17,  1'b0, 1'b0, 0);
        wait_idle(END_CYCLES);
        if (tracker.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, tracker.pending());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
